FILE: sv/component_solidity_filter_core_defines.svh
// Assertion macros shared by the solidity filter checker.
`ifndef COMPONENT_SOLIDITY_FILTER_CORE_DEFINES_SVH
`define COMPONENT_SOLIDITY_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CSF_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define CSF_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define CSF_ASSERT_ALWAYS_NEXT(name, clk, ante, cons, msg) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/csf_pkg.sv
// Shared constants and types of the component solidity filter.
`timescale 1ns / 1ps
`default_nettype none

package csf_pkg;

   // Table geometry
   localparam int MAX_LABELS = 256;
   localparam int COORD_BITS = 11;
   localparam int LBL_AW     = $clog2(MAX_LABELS);

   // Field widths
   localparam int LABEL_W = 8;
   localparam int ROW_W   = 11;
   localparam int XCOL_W  = 11;
   localparam int COUNT_W = 23;
   localparam int SIZE_W  = COORD_BITS + 1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Thresholds and CSR port
   localparam int THR_W  = 16;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic [THR_W-1:0] SPARSE_RESET = 16'd3200;
   localparam logic [THR_W-1:0] SOLID_RESET  = 16'd48;
   localparam logic REG_SPARSE = 1'b0;
   localparam logic REG_SOLID  = 1'b1;

   // Shared multiplier and area
   localparam int MUL_A_W    = COUNT_W;
   localparam int MUL_B_W    = THR_W;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int AREA_SHIFT = 5;
   localparam int AREA_W     = MUL_P_W + AREA_SHIFT;

   // Command codes
   typedef enum logic [1:0] {
      FUNC_CLEAR    = 2'd0,
      FUNC_ACCUM    = 2'd1,
      FUNC_CLASSIFY = 2'd2,
      FUNC_RELABEL  = 2'd3
   } csf_func_type;

   // One label's statistics
   typedef struct packed {
      logic [COUNT_W-1:0]    count;
      logic [COORD_BITS-1:0] min_x;
      logic [COORD_BITS-1:0] max_x;
      logic [COORD_BITS-1:0] min_y;
      logic [COORD_BITS-1:0] max_y;
   } csf_entry_type;

   // Sequencer to table controls
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic              clr;
      logic              flag_rd;
      logic              flag_wr;
      logic              flag_val;
      logic [LBL_AW-1:0] idx;
      logic [LBL_AW-1:0] flag_idx;
   } csf_tbl_ctl_type;

endpackage

`default_nettype wire

FILE: sv/csf_table.sv
// Label statistics memory and invalid-flag memory with reset-value tracking.
`timescale 1ns / 1ps
`default_nettype none

module csf_table (
   input  wire                      clock,
   input  wire                      reset,
   input  csf_pkg::csf_tbl_ctl_type ctl,
   input  csf_pkg::csf_entry_type   wdata,
   output csf_pkg::csf_entry_type   rdata,
   output logic                     flag
);

   csf_pkg::csf_entry_type             mem [csf_pkg::MAX_LABELS];
   logic                               flag_mem [csf_pkg::MAX_LABELS];
   logic [csf_pkg::MAX_LABELS-1:0]     vld_ff;
   logic                               flag_ok_ff;
   csf_pkg::csf_entry_type             mem_q_ff;
   logic                               vld_q_ff;
   logic                               flag_q_ff;

   // Entry valid bits; an entry not yet written reads as its cleared value
   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         vld_ff     <= '0;
         flag_ok_ff <= 1'b0;
      end else begin
         if (ctl.wr) begin
            vld_ff[ctl.idx] <= 1'b1;
         end
         if (ctl.flag_wr) begin
            flag_ok_ff <= 1'b1;
         end
      end
   end

   // Statistics memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[ctl.idx] <= wdata;
      end
      if (ctl.rd) begin
         mem_q_ff <= mem[ctl.idx];
         vld_q_ff <= vld_ff[ctl.idx];
      end
   end

   // Flag memory; classify writes every entry, so one bit marks it filled
   always_ff @(posedge clock) begin
      if (ctl.flag_wr) begin
         flag_mem[ctl.flag_idx] <= ctl.flag_val;
      end
      if (ctl.flag_rd) begin
         flag_q_ff <= flag_ok_ff & flag_mem[ctl.idx];
      end
   end

   always_comb begin
      if (vld_q_ff) begin
         rdata = mem_q_ff;
      end else begin
         rdata.count = '0;
         rdata.min_x = '1;
         rdata.max_x = '0;
         rdata.min_y = '1;
         rdata.max_y = '0;
      end
   end

   assign flag = flag_q_ff;

endmodule

`default_nettype wire

FILE: sv/csf_mul.sv
// Shared registered multiplier for box area and threshold products.
`timescale 1ns / 1ps
`default_nettype none

module csf_mul (
   input  wire                               clock,
   input  wire  [csf_pkg::MUL_A_W-1:0]       mul_a,
   input  wire  [csf_pkg::MUL_B_W-1:0]       mul_b,
   output logic [csf_pkg::MUL_P_W-1:0]       mul_p
);

   logic [csf_pkg::MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= csf_pkg::MUL_P_W'(mul_a) * csf_pkg::MUL_P_W'(mul_b);
   end

   assign mul_p = prod_ff;

endmodule

`default_nettype wire

FILE: sv/component_solidity_filter_core.sv
// Top level of the component solidity filter: sequencer, CSRs and output register.
//
//   channel | direction | transfer when          | payload
//   req     | in        | req_valid & req_ready | func, label, row, x_start, x_end
//   rsp     | out       | rsp_valid & rsp_ready | new_label, rejected
//   apb     | in        | psel&penable&pwrite   | paddr, pwdata (prdata on read)
//
// Clear completes in the idle state; accumulate reads then writes one table entry;
// relabel waits through any output stall; classify passes through the area, sparse,
// solid and write states per label, using the one shared multiplier for all three products.
// Synchronous active-high reset empties the tables through per-entry valid bits
// at once; no clearing pass is needed. req_ready is low while a command runs.
`timescale 1ns / 1ps
`default_nettype none

module component_solidity_filter_core (
   input  wire                                clock,
   input  wire                                reset,
   // input item channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [1:0]                         req_func,
   input  wire  [csf_pkg::LABEL_W-1:0]        req_label,
   input  wire  [csf_pkg::ROW_W-1:0]          req_row,
   input  wire  [csf_pkg::XCOL_W-1:0]         req_x_start,
   input  wire  [csf_pkg::XCOL_W-1:0]         req_x_end,
   // result channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [csf_pkg::LABEL_W-1:0]        rsp_new_label,
   output logic                               rsp_rejected,
   // configuration port
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [csf_pkg::CSR_AW-1:0]         paddr,
   input  wire  [csf_pkg::CSR_DW-1:0]         pwdata,
   output logic [csf_pkg::CSR_DW-1:0]         prdata,
   output logic                               pready
);

   localparam int CB = csf_pkg::COORD_BITS;
   localparam int AW = csf_pkg::LBL_AW;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC_WR,
      ST_REL_OUT,
      ST_CLS_AREA,
      ST_CLS_SPARSE,
      ST_CLS_SOLID,
      ST_CLS_WR
   } state_type;

   state_type                          state_ff;
   logic [csf_pkg::THR_W-1:0]          sparse_thr_ff;
   logic [csf_pkg::THR_W-1:0]          solid_thr_ff;
   logic                               rsp_valid_ff;
   logic [csf_pkg::LABEL_W-1:0]        rsp_label_ff;
   logic                               rsp_rej_ff;
   logic [csf_pkg::LABEL_W-1:0]        label_ff;
   logic [CB-1:0]                      row_ff;
   logic [CB-1:0]                      xs_ff;
   logic [CB-1:0]                      xe_ff;
   logic [AW-1:0]                      cls_idx_ff;
   logic [csf_pkg::AREA_W-1:0]         area_ff;
   logic                               skip_ff;
   logic                               below_ff;

   logic                               req_xfer;
   logic                               csr_wr;
   logic [31:0]                        req_lab32;
   logic [31:0]                        lab32;
   logic                               lab_ok;
   logic [CB-1:0]                      row_c;
   logic [CB-1:0]                      xs_c;
   logic [CB-1:0]                      xe_c;
   logic                               out_free;
   logic                               cls_last;

   csf_pkg::csf_tbl_ctl_type           tbl_ctl;
   csf_pkg::csf_entry_type             tbl_wdata;
   csf_pkg::csf_entry_type             tbl_rdata;
   logic                               tbl_flag;

   logic [csf_pkg::MUL_A_W-1:0]        mul_a;
   logic [csf_pkg::MUL_B_W-1:0]        mul_b;
   logic [csf_pkg::MUL_P_W-1:0]        mul_p;
   logic [csf_pkg::AREA_W-1:0]         prod_ext;

   logic [CB:0]                        seg_len;
   logic [csf_pkg::COUNT_W:0]          count_sum;
   logic [CB:0]                        box_w;
   logic [CB:0]                        box_h;
   logic                               box_bad;

   // Handshakes and CSR access
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == csf_pkg::REG_SOLID) ? csf_pkg::CSR_DW'(solid_thr_ff)
                                                        : csf_pkg::CSR_DW'(sparse_thr_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_label = rsp_label_ff;
   assign rsp_rejected  = rsp_rej_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // Label range and coordinates taken modulo the table width
   assign req_lab32 = 32'(req_label);
   assign lab32     = 32'(label_ff);
   assign lab_ok    = (lab32 < 32'(csf_pkg::MAX_LABELS));
   always_comb begin
      logic [31:0] r32;
      logic [31:0] s32;
      logic [31:0] e32;
      r32  = 32'(req_row);
      s32  = 32'(req_x_start);
      e32  = 32'(req_x_end);
      row_c = r32[CB-1:0];
      xs_c  = s32[CB-1:0];
      xe_c  = e32[CB-1:0];
   end

   assign cls_last = (cls_idx_ff == AW'(csf_pkg::MAX_LABELS - 1));
   assign prod_ext = csf_pkg::AREA_W'(mul_p);

   // Segment update for accumulate
   assign seg_len   = {1'b0, xe_ff} - {1'b0, xs_ff} + (CB+1)'(1);
   assign count_sum = {1'b0, tbl_rdata.count} + (csf_pkg::COUNT_W+1)'(seg_len);
   always_comb begin
      tbl_wdata.count = count_sum[csf_pkg::COUNT_W] ? csf_pkg::COUNT_MAX
                                                     : count_sum[csf_pkg::COUNT_W-1:0];
      tbl_wdata.min_x = (xs_ff < tbl_rdata.min_x) ? xs_ff : tbl_rdata.min_x;
      tbl_wdata.max_x = (xe_ff > tbl_rdata.max_x) ? xe_ff : tbl_rdata.max_x;
      tbl_wdata.min_y = (row_ff < tbl_rdata.min_y) ? row_ff : tbl_rdata.min_y;
      tbl_wdata.max_y = (row_ff > tbl_rdata.max_y) ? row_ff : tbl_rdata.max_y;
   end

   // Box size for classify
   assign box_w   = {1'b0, tbl_rdata.max_x} - {1'b0, tbl_rdata.min_x} + (CB+1)'(1);
   assign box_h   = {1'b0, tbl_rdata.max_y} - {1'b0, tbl_rdata.min_y} + (CB+1)'(1);
   assign box_bad = (tbl_rdata.max_x < tbl_rdata.min_x) ||
                    (tbl_rdata.max_y < tbl_rdata.min_y);

   // Multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_CLS_AREA: begin
            mul_a = csf_pkg::MUL_A_W'(box_w);
            mul_b = csf_pkg::MUL_B_W'(box_h);
         end
         ST_CLS_SPARSE: begin
            mul_a = tbl_rdata.count;
            mul_b = sparse_thr_ff;
         end
         ST_CLS_SOLID: begin
            mul_a = tbl_rdata.count;
            mul_b = solid_thr_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Table controls
   always_comb begin
      logic [31:0] nxt32;
      nxt32            = 32'(cls_idx_ff) + 32'd1;
      tbl_ctl          = '0;
      tbl_ctl.flag_idx = cls_idx_ff;
      tbl_ctl.flag_val = skip_ff || below_ff || (prod_ext > area_ff);
      unique case (state_ff)
         ST_IDLE: begin
            tbl_ctl.idx = req_lab32[AW-1:0];
            if (req_xfer) begin
               case (req_func)
                  csf_pkg::FUNC_CLEAR:    tbl_ctl.clr     = 1'b1;
                  csf_pkg::FUNC_ACCUM:    tbl_ctl.rd      = 1'b1;
                  csf_pkg::FUNC_RELABEL:  tbl_ctl.flag_rd = 1'b1;
                  default: begin
                     tbl_ctl.rd  = 1'b1;
                     tbl_ctl.idx = '0;
                  end
               endcase
            end
         end
         ST_ACC_WR: begin
            tbl_ctl.idx = lab32[AW-1:0];
            tbl_ctl.wr  = lab_ok && (xe_ff >= xs_ff);
         end
         ST_CLS_WR: begin
            tbl_ctl.flag_wr = 1'b1;
            tbl_ctl.rd      = !cls_last;
            tbl_ctl.idx     = nxt32[AW-1:0];
         end
         default: begin
            tbl_ctl.idx = cls_idx_ff;
         end
      endcase
   end

   // Sequencer, CSRs and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         sparse_thr_ff <= csf_pkg::SPARSE_RESET;
         solid_thr_ff  <= csf_pkg::SOLID_RESET;
      end else begin
         if (csr_wr) begin
            if (paddr[2] == csf_pkg::REG_SOLID) begin
               solid_thr_ff <= pwdata[csf_pkg::THR_W-1:0];
            end else begin
               sparse_thr_ff <= pwdata[csf_pkg::THR_W-1:0];
            end
         end
         // a relabel result loads the register in the same cycle it drains
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_REL_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  label_ff   <= req_label;
                  row_ff     <= row_c;
                  xs_ff      <= xs_c;
                  xe_ff      <= xe_c;
                  cls_idx_ff <= '0;
                  case (req_func)
                     csf_pkg::FUNC_CLEAR:   state_ff <= ST_IDLE;
                     csf_pkg::FUNC_ACCUM:   state_ff <= ST_ACC_WR;
                     csf_pkg::FUNC_RELABEL: state_ff <= ST_REL_OUT;
                     default:               state_ff <= ST_CLS_AREA;
                  endcase
               end
            end
            ST_ACC_WR: begin
               state_ff <= ST_IDLE;
            end
            ST_REL_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_rej_ff   <= !lab_ok || tbl_flag;
                  rsp_label_ff <= (!lab_ok || tbl_flag) ? '0 : label_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_CLS_AREA: begin
               skip_ff  <= (tbl_rdata.count == '0) || box_bad;
               state_ff <= ST_CLS_SPARSE;
            end
            ST_CLS_SPARSE: begin
               area_ff  <= prod_ext << csf_pkg::AREA_SHIFT;
               state_ff <= ST_CLS_SOLID;
            end
            ST_CLS_SOLID: begin
               below_ff <= (prod_ext < area_ff);
               state_ff <= ST_CLS_WR;
            end
            ST_CLS_WR: begin
               if (cls_last) begin
                  state_ff <= ST_IDLE;
               end else begin
                  cls_idx_ff <= cls_idx_ff + AW'(1);
                  state_ff   <= ST_CLS_AREA;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   csf_table u_table (
      .clock (clock),
      .reset (reset),
      .ctl   (tbl_ctl),
      .wdata (tbl_wdata),
      .rdata (tbl_rdata),
      .flag  (tbl_flag)
   );

   csf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

endmodule

`default_nettype wire

FILE: sv/csf_checker.sv
// Port-level checker for the component solidity filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "component_solidity_filter_core_defines.svh"

module csf_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire [1:0]                   req_func,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [csf_pkg::LABEL_W-1:0]  rsp_new_label,
   input wire                         rsp_rejected,
   input wire                         pready
);

   // A stalled result holds
   `CSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_label) && $stable(rsp_rejected), "stalled result changed")

   // A rejected segment always maps to label zero
   `CSF_ASSERT_NOW(a_rej_zero, clock, reset, rsp_valid && rsp_rejected, rsp_new_label == '0, "rejected result with nonzero label")

   // Every command but clear keeps the block busy for the next cycle
   `CSF_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready && (req_func != csf_pkg::FUNC_CLEAR), !req_ready, "ready right after a multi-cycle command")

   // Reset leaves the block idle with no pending result
   `CSF_ASSERT_ALWAYS_NEXT(a_reset_idle, clock, reset, req_ready && !rsp_valid && pready, "block not idle after reset")

endmodule

bind component_solidity_filter_core csf_checker u_csf_checker (.*);

`default_nettype wire
